>>> src/tseq_pkg.sv
// Shared constants and register codes for the touch sample to event queue unit.
package tseq_pkg;

    // Port widths
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int WORD_W   = 16;
    localparam int EVENT_W  = 64;
    localparam int COUNT_W  = 8;

    // Datapath widths
    localparam int PROD_W  = 36;
    localparam int RES_W   = 38;
    localparam int RT_W    = 26;
    localparam int CAL_W   = 24;
    localparam int STEP_W  = 6;

    // Serial step counts
    localparam int MUL_STEPS = 12;
    localparam int DIV_STEPS = 36;

    // Defaults, fixed plate constant and rounding bias
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam logic [SAMPLE_W-1:0] Y_PLATE_RES = 12'd485;
    localparam logic [RES_W-1:0] ROUND_HALF = 38'd2048;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_MODE = 3'd0,
        REG_X_PLATE       = 3'd1,
        REG_DOWN_THR      = 3'd2,
        REG_UP_THR        = 3'd3,
        REG_X_GAIN        = 3'd4,
        REG_X_OFFSET      = 3'd5,
        REG_Y_GAIN        = 3'd6,
        REG_Y_OFFSET      = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic                  RST_PRESSURE_MODE = 1'b1;
    localparam logic [SAMPLE_W-1:0]   RST_X_PLATE       = 12'd330;
    localparam logic [WORD_W-1:0]     RST_DOWN_THR      = 16'd0;
    localparam logic [WORD_W-1:0]     RST_UP_THR        = 16'd0;
    localparam logic [WORD_W-1:0]     RST_X_GAIN        = 16'd20;
    localparam logic [WORD_W-1:0]     RST_X_OFFSET      = 16'd0;
    localparam logic [WORD_W-1:0]     RST_Y_GAIN        = 16'd13;
    localparam logic [WORD_W-1:0]     RST_Y_OFFSET      = 16'd0;

    // Input item kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_POP    = 1'b1;

endpackage

>>> src/touch_sample_to_event_queue_unit.sv
// Touch sample processing with pen hysteresis, calibration and an event ring.
//
//  Channel   Direction  Handshake               Payload
//  s_        in         s_tvalid / s_tready     s_tdata sample, s_tuser kind
//  m_        out        m_tvalid / m_tready     m_tdata event, m_tuser valid
//  cfg_      in         cfg_wr_en               cfg_index, cfg_data
//
// A sample item passes through bit-serial multiplication, bit-serial restoring
// division by Z1, rounding, and then hysteresis and queue update, which load its
// result. A pop item needs no arithmetic, since the oldest entry already sits in
// the read register: acceptance moves it to the pop state, which loads its result.
// s_tready returns the cycle after a result is loaded; a stalled output holds the
// unit in its last step.
// Reset is synchronous, active low, and clears control and configuration registers.
module touch_sample_to_event_queue_unit #(
    parameter int QUEUE_DEPTH = tseq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: x_sample, y_sample, z1_sample, z2_sample, time_stamp
    input  logic [tseq_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: action
    input  logic [0:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: pen_is_down, event_x, event_y, event_pressure, event_time,
    //        oldest_dropped, queued_count, zero fill
    output logic [tseq_pkg::M_DATA_W-1:0]   m_tdata,
    // tuser: event_valid
    output logic [0:0]                      m_tuser,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [tseq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tseq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tseq_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_RES,
        ST_POP
    } state_t;

    // Control state
    state_t               state_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 pen_reg;
    logic [QW-1:0]        wr_idx_reg;
    logic [QW-1:0]        rd_idx_reg;
    logic [CW-1:0]        count_reg;
    logic                 m_tvalid_reg;

    // Configuration registers
    logic                 mode_reg;
    logic [SAMPLE_W-1:0]  xplate_reg;
    logic [WORD_W-1:0]    down_thr_reg;
    logic [WORD_W-1:0]    up_thr_reg;
    logic [WORD_W-1:0]    x_gain_reg;
    logic [WORD_W-1:0]    x_off_reg;
    logic [WORD_W-1:0]    y_gain_reg;
    logic [WORD_W-1:0]    y_off_reg;

    // Datapath registers
    logic [SAMPLE_W-1:0]  z1_reg;
    logic [WORD_W-1:0]    ts_reg;
    logic                 neg_reg;
    logic [SAMPLE_W-1:0]  mag_sh_reg;
    logic [PROD_W-1:0]    a_sh_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [SAMPLE_W-1:0]  x_sh_reg;
    logic [SAMPLE_W-1:0]  y_sh_reg;
    logic [CAL_W-1:0]     gx_sh_reg;
    logic [CAL_W-1:0]     gy_sh_reg;
    logic [CAL_W-1:0]     cx_acc_reg;
    logic [CAL_W-1:0]     cy_acc_reg;
    logic [CAL_W-1:0]     yterm_reg;
    logic signed [RES_W-1:0] r_reg;
    logic [EVENT_W-1:0]   rd_data_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 m_tuser_reg;

    // Event memory
    logic [EVENT_W-1:0]   mem [QUEUE_DEPTH];

    // Input field views
    logic [SAMPLE_W-1:0]  in_x;
    logic [SAMPLE_W-1:0]  in_y;
    logic [SAMPLE_W-1:0]  in_z1;
    logic [SAMPLE_W-1:0]  in_z2;
    logic [WORD_W-1:0]    in_ts;
    logic [SAMPLE_W-1:0]  z1_fixed;
    logic [SAMPLE_W:0]    z_diff;
    logic                 setup_neg;
    logic [SAMPLE_W-1:0]  setup_mag;
    logic [2*SAMPLE_W-1:0] plate_prod;
    logic [2*SAMPLE_W-1:0] yplate_prod;

    assign in_x  = s_tdata[11:0];
    assign in_y  = s_tdata[23:12];
    assign in_z1 = s_tdata[35:24];
    assign in_z2 = s_tdata[47:36];
    assign in_ts = s_tdata[63:48];

    // Full-width products loaded when an item is accepted
    assign plate_prod  = xplate_reg * in_x;
    assign yplate_prod = Y_PLATE_RES * in_y;

    // Z1 of zero counts as one; pick the multiplier of the selected equation
    always_comb begin
        z1_fixed = (in_z1 == '0) ? SAMPLE_W'(1) : in_z1;
        z_diff   = {1'b0, in_z2} - {1'b0, z1_fixed};
        if (mode_reg) begin
            setup_neg = 1'b0;
            setup_mag = SAMPLE_W'(13'd4096 - {1'b0, z1_fixed});
        end else begin
            setup_neg = z_diff[SAMPLE_W];
            setup_mag = z_diff[SAMPLE_W] ? SAMPLE_W'(-z_diff) : z_diff[SAMPLE_W-1:0];
        end
    end

    // Handshake
    logic accept;
    logic out_free;
    logic res_fire;
    logic pop_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign res_fire = (state_reg == ST_RES) && out_free;
    assign pop_fire = (state_reg == ST_POP) && out_free;

    // One division step: shift in the next dividend bit and try to subtract
    logic [SAMPLE_W:0]    div_trial;
    logic [SAMPLE_W:0]    div_diff;
    logic                 div_fits;

    always_comb begin
        div_trial = {rem_reg, quo_reg[PROD_W-1]};
        div_diff  = div_trial - {1'b0, z1_reg};
        div_fits  = (div_trial >= {1'b0, z1_reg});
    end

    // Signed quotient, plate term and rounding bias
    logic signed [RES_W-1:0] q_signed;
    logic signed [RES_W-1:0] r_next;

    always_comb begin
        q_signed = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        r_next   = q_signed - $signed({14'd0, yterm_reg}) + $signed(ROUND_HALF);
    end

    // Hysteresis, calibration and the event that would be queued
    logic signed [RT_W-1:0] rt;
    logic                 pen_new;
    logic [WORD_W-1:0]    cal_x;
    logic [WORD_W-1:0]    cal_y;
    logic [EVENT_W-1:0]   ev_new;
    logic                 push;
    logic                 full;
    logic                 pop_take;
    logic [CW-1:0]        count_next;
    logic [M_DATA_W-1:0]  m_tdata_next;
    logic                 m_tuser_next;

    always_comb begin
        rt = r_reg[RES_W-1:12];
        if (!pen_reg && (rt < $signed({10'd0, down_thr_reg}))) begin
            pen_new = 1'b1;
        end else if (pen_reg && (rt > $signed({10'd0, up_thr_reg}))) begin
            pen_new = 1'b0;
        end else begin
            pen_new = pen_reg;
        end
        cal_x    = cx_acc_reg[23:8] + x_off_reg;
        cal_y    = cy_acc_reg[23:8] + y_off_reg;
        ev_new   = {ts_reg, rt[WORD_W-1:0], cal_y, cal_x};
        push     = res_fire && pen_new;
        full     = (count_reg == CW'(QUEUE_DEPTH));
        pop_take = pop_fire && (count_reg != '0);

        count_next = count_reg;
        if (push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (pop_take) begin
            count_next = count_reg - CW'(1);
        end

        // Result item: event fields zero unless an event was queued or popped
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        if (state_reg == ST_RES) begin
            m_tdata_next[0] = pen_new;
            if (pen_new) begin
                m_tdata_next[64:1] = ev_new;
                m_tdata_next[65]   = full;
                m_tuser_next       = 1'b1;
            end
        end else begin
            m_tdata_next[0] = pen_reg;
            if (count_reg != '0) begin
                m_tdata_next[64:1] = rd_data_reg;
                m_tuser_next       = 1'b1;
            end
        end
        m_tdata_next[73:66] = COUNT_W'(count_next);
    end

    // Queue index wrap
    function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] idx);
        next_idx = (idx == QW'(QUEUE_DEPTH - 1)) ? '0 : idx + QW'(1);
    endfunction

    // Sequencer, queue control, configuration and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            pen_reg      <= 1'b0;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= RST_PRESSURE_MODE;
            xplate_reg   <= RST_X_PLATE;
            down_thr_reg <= RST_DOWN_THR;
            up_thr_reg   <= RST_UP_THR;
            x_gain_reg   <= RST_X_GAIN;
            x_off_reg    <= RST_X_OFFSET;
            y_gain_reg   <= RST_Y_GAIN;
            y_off_reg    <= RST_Y_OFFSET;
        end else begin
            if (m_tready && !(res_fire || pop_fire)) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PRESSURE_MODE: mode_reg     <= cfg_data[0];
                    REG_X_PLATE:       xplate_reg   <= cfg_data[SAMPLE_W-1:0];
                    REG_DOWN_THR:      down_thr_reg <= cfg_data;
                    REG_UP_THR:        up_thr_reg   <= cfg_data;
                    REG_X_GAIN:        x_gain_reg   <= cfg_data;
                    REG_X_OFFSET:      x_off_reg    <= cfg_data;
                    REG_Y_GAIN:        y_gain_reg   <= cfg_data;
                    REG_Y_OFFSET:      y_off_reg    <= cfg_data;
                    default:           mode_reg     <= mode_reg;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (accept) begin
                        state_reg <= (s_tuser[0] == ACT_POP) ? ST_POP : ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DIV: begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_FIX;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_FIX: begin
                    state_reg <= ST_RES;
                end
                ST_RES: begin
                    if (res_fire) begin
                        pen_reg      <= pen_new;
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        if (push) begin
                            wr_idx_reg <= next_idx(wr_idx_reg);
                            if (full) begin
                                rd_idx_reg <= next_idx(rd_idx_reg);
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POP: begin
                    if (pop_fire) begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        if (pop_take) begin
                            rd_idx_reg <= next_idx(rd_idx_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Serial multiply, serial divide and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            z1_reg     <= z1_fixed;
            ts_reg     <= in_ts;
            neg_reg    <= setup_neg;
            mag_sh_reg <= setup_mag;
            a_sh_reg   <= PROD_W'(plate_prod);
            quo_reg    <= '0;
            rem_reg    <= '0;
            x_sh_reg   <= in_x;
            y_sh_reg   <= in_y;
            gx_sh_reg  <= {{(CAL_W - WORD_W){x_gain_reg[WORD_W-1]}}, x_gain_reg};
            gy_sh_reg  <= {{(CAL_W - WORD_W){y_gain_reg[WORD_W-1]}}, y_gain_reg};
            cx_acc_reg <= '0;
            cy_acc_reg <= '0;
            yterm_reg  <= mode_reg ? CAL_W'(yplate_prod) : '0;
        end

        // One multiplier bit per cycle for the product and both calibrations
        if (state_reg == ST_MUL) begin
            if (mag_sh_reg[0]) begin
                quo_reg <= quo_reg + a_sh_reg;
            end
            if (x_sh_reg[0]) begin
                cx_acc_reg <= cx_acc_reg + gx_sh_reg;
            end
            if (y_sh_reg[0]) begin
                cy_acc_reg <= cy_acc_reg + gy_sh_reg;
            end
            mag_sh_reg <= mag_sh_reg >> 1;
            x_sh_reg   <= x_sh_reg >> 1;
            y_sh_reg   <= y_sh_reg >> 1;
            a_sh_reg   <= a_sh_reg << 1;
            gx_sh_reg  <= gx_sh_reg << 1;
            gy_sh_reg  <= gy_sh_reg << 1;
        end

        // One quotient bit per cycle; the product is shifted out as it goes
        if (state_reg == ST_DIV) begin
            rem_reg <= div_fits ? div_diff[SAMPLE_W-1:0] : div_trial[SAMPLE_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], div_fits};
        end

        if (state_reg == ST_FIX) begin
            r_reg <= r_next;
        end

        if (res_fire || pop_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // Event memory with registered read at the oldest entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_idx_reg] <= ev_new;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
